// File: rtl/source_tokenizer_defines.svh
`ifndef SOURCE_TOKENIZER_DEFINES_SVH
`define SOURCE_TOKENIZER_DEFINES_SVH
// concurrent check with synchronous reset
`define ST_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check that also holds during reset
`define ST_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: rtl/stok_pkg.sv
`timescale 1ns / 1ps
package stok_pkg;
   localparam int POSITION_BITS = 24;
   localparam int KEYWORD_MAX = 7;
   localparam int FIELD_BITS = 24;
   localparam int KIND_BITS = 6;
   localparam int MAX_OUT = 3;

   localparam logic [5:0] K_LPAREN = 6'd0;
   localparam logic [5:0] K_RPAREN = 6'd1;
   localparam logic [5:0] K_LBRACE = 6'd2;
   localparam logic [5:0] K_RBRACE = 6'd3;
   localparam logic [5:0] K_COMMA = 6'd4;
   localparam logic [5:0] K_DOT = 6'd5;
   localparam logic [5:0] K_MINUS = 6'd6;
   localparam logic [5:0] K_PLUS = 6'd7;
   localparam logic [5:0] K_SEMI = 6'd8;
   localparam logic [5:0] K_SLASH = 6'd9;
   localparam logic [5:0] K_STAR = 6'd10;
   localparam logic [5:0] K_BANG = 6'd11;
   localparam logic [5:0] K_EQUAL = 6'd13;
   localparam logic [5:0] K_GREATER = 6'd15;
   localparam logic [5:0] K_LESS = 6'd17;
   localparam logic [5:0] K_IDENT = 6'd19;
   localparam logic [5:0] K_STRING = 6'd20;
   localparam logic [5:0] K_NUMBER = 6'd21;
   localparam logic [5:0] K_AND = 6'd22;
   localparam logic [5:0] K_CLASS = 6'd23;
   localparam logic [5:0] K_ELSE = 6'd24;
   localparam logic [5:0] K_FALSE = 6'd25;
   localparam logic [5:0] K_FN = 6'd26;
   localparam logic [5:0] K_FOR = 6'd27;
   localparam logic [5:0] K_IF = 6'd28;
   localparam logic [5:0] K_IN = 6'd29;
   localparam logic [5:0] K_LET = 6'd30;
   localparam logic [5:0] K_NULL = 6'd31;
   localparam logic [5:0] K_OR = 6'd32;
   localparam logic [5:0] K_PRINTLN = 6'd33;
   localparam logic [5:0] K_RETURN = 6'd34;
   localparam logic [5:0] K_SUPER = 6'd35;
   localparam logic [5:0] K_SELF = 6'd36;
   localparam logic [5:0] K_TRUE = 6'd37;
   localparam logic [5:0] K_WHILE = 6'd38;
   localparam logic [5:0] K_END = 6'd39;
   localparam logic [5:0] K_ERROR = 6'd40;

   typedef enum logic [10:0] {
      M_IDLE   = 11'b00000000001,
      M_SLASH  = 11'b00000000010,
      M_LINEC  = 11'b00000000100,
      M_BLOCK  = 11'b00000001000,
      M_BSTAR  = 11'b00000010000,
      M_IDENT  = 11'b00000100000,
      M_NUM    = 11'b00001000000,
      M_NUMDOT = 11'b00010000000,
      M_FRAC   = 11'b00100000000,
      M_STR    = 11'b01000000000,
      M_OP     = 11'b10000000000
   } mode_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [5:0] op_kind(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         8'h21: k = K_BANG;
         8'h3d: k = K_EQUAL;
         8'h3e: k = K_GREATER;
         default: k = K_LESS;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] single_kind(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         8'h28: k = K_LPAREN;
         8'h29: k = K_RPAREN;
         8'h7b: k = K_LBRACE;
         8'h7d: k = K_RBRACE;
         8'h2c: k = K_COMMA;
         8'h2e: k = K_DOT;
         8'h2d: k = K_MINUS;
         8'h2b: k = K_PLUS;
         8'h3b: k = K_SEMI;
         8'h2a: k = K_STAR;
         default: k = K_ERROR;
      endcase
      return k;
   endfunction
endpackage

// File: rtl/stok_stream_if.sv
`timescale 1ns / 1ps
interface stok_stream_if #(parameter int WIDTH = 9);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/source_tokenizer.sv
`timescale 1ns / 1ps
// Streaming lexer: one source byte (or the end marker) per req item; a byte
// can produce up to three rsp items, held in a result register and delivered
// one per cycle while rsp is ready, the last flagged by out_last. The next req item is
// taken in the same cycle the final rsp item of the previous byte leaves.
module source_tokenizer #(
   parameter int POSITION_BITS = stok_pkg::POSITION_BITS,
   parameter int KEYWORD_MAX = stok_pkg::KEYWORD_MAX
) (
   input logic clock,
   input logic reset,
   stok_stream_if.sink req,
   stok_stream_if.source rsp
);
   stok_scan #(.POSITION_BITS(POSITION_BITS), .KEYWORD_MAX(KEYWORD_MAX)) u_scan (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready),
      .in_char(req.payload[7:0]), .in_end(req.payload[8]),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_kind(rsp.payload[5:0]), .out_start(rsp.payload[29:6]),
      .out_length(rsp.payload[53:30]), .out_line(rsp.payload[77:54]),
      .out_last(rsp.payload[78]));
endmodule

// File: rtl/stok_keyword.sv
`timescale 1ns / 1ps
module stok_keyword #(
   parameter int KEYWORD_MAX = stok_pkg::KEYWORD_MAX
) (
   input  logic [KEYWORD_MAX*8-1:0]        prefix,
   input  logic [$clog2(KEYWORD_MAX+2)-1:0] length,
   output logic [5:0]                      kind
);
   localparam int LW = $clog2(KEYWORD_MAX + 2);

   function automatic logic hit(input logic [KEYWORD_MAX*8-1:0] p,
                                input logic [LW-1:0] l, input logic [55:0] w,
                                input int n);
      logic ok;
      ok = (l == LW'(n));
      for (int i = 0; i < 7; i++) begin
         if (i < n && p[i*8 +: 8] != w[(6-i)*8 +: 8]) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

   always_comb begin
      kind = stok_pkg::K_IDENT;
      if (hit(prefix, length, {"and", 32'd0}, 3)) kind = stok_pkg::K_AND;
      if (hit(prefix, length, {"class", 16'd0}, 5)) kind = stok_pkg::K_CLASS;
      if (hit(prefix, length, {"else", 24'd0}, 4)) kind = stok_pkg::K_ELSE;
      if (hit(prefix, length, {"false", 16'd0}, 5)) kind = stok_pkg::K_FALSE;
      if (hit(prefix, length, {"fn", 40'd0}, 2)) kind = stok_pkg::K_FN;
      if (hit(prefix, length, {"for", 32'd0}, 3)) kind = stok_pkg::K_FOR;
      if (hit(prefix, length, {"if", 40'd0}, 2)) kind = stok_pkg::K_IF;
      if (hit(prefix, length, {"in", 40'd0}, 2)) kind = stok_pkg::K_IN;
      if (hit(prefix, length, {"let", 32'd0}, 3)) kind = stok_pkg::K_LET;
      if (hit(prefix, length, {"null", 24'd0}, 4)) kind = stok_pkg::K_NULL;
      if (hit(prefix, length, {"or", 40'd0}, 2)) kind = stok_pkg::K_OR;
      if (hit(prefix, length, "println", 7)) kind = stok_pkg::K_PRINTLN;
      if (hit(prefix, length, {"return", 8'd0}, 6)) kind = stok_pkg::K_RETURN;
      if (hit(prefix, length, {"super", 16'd0}, 5)) kind = stok_pkg::K_SUPER;
      if (hit(prefix, length, {"self", 24'd0}, 4)) kind = stok_pkg::K_SELF;
      if (hit(prefix, length, {"true", 24'd0}, 4)) kind = stok_pkg::K_TRUE;
      if (hit(prefix, length, {"while", 16'd0}, 5)) kind = stok_pkg::K_WHILE;
   end
endmodule

// File: rtl/stok_scan.sv
`timescale 1ns / 1ps
`include "source_tokenizer_defines.svh"
module stok_scan #(
   parameter int POSITION_BITS = stok_pkg::POSITION_BITS,
   parameter int KEYWORD_MAX = stok_pkg::KEYWORD_MAX
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [7:0]  in_char,
   input  logic        in_end,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [5:0]  out_kind,
   output logic [23:0] out_start,
   output logic [23:0] out_length,
   output logic [23:0] out_line,
   output logic        out_last
);
   localparam int PB = POSITION_BITS;
   localparam int LW = $clog2(KEYWORD_MAX + 2);

   typedef struct packed {
      logic [5:0]    kind;
      logic [PB-1:0] start;
      logic [PB-1:0] len;
   } tok_type;

   stok_pkg::mode_type     mode_ff, mode_in;
   logic [7:0]             look_ff, look_in;
   logic [PB-1:0]          pos_ff, pos_in;
   logic [PB-1:0]          lex_ff, lex_in;
   logic [23:0]            line_ff, line_in;
   logic [KEYWORD_MAX*8-1:0] pre_ff, pre_in;
   logic [LW-1:0]          ilen_ff, ilen_in;

   tok_type    tok_ff [3], tok_in [3];
   logic [23:0] tline_ff [3], tline_in [3];
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] idx_ff, idx_in;
   logic       accept;
   logic       end_take;
   logic [5:0] kw_kind;

   stok_keyword #(.KEYWORD_MAX(KEYWORD_MAX)) u_kw (
      .prefix(pre_ff), .length(ilen_ff), .kind(kw_kind));

   assign in_ready = (cnt_ff == 2'd0) || (out_ready && idx_ff + 2'd1 == cnt_ff);
   assign accept = in_valid && in_ready;
   assign end_take = accept && in_end;
   assign out_valid = cnt_ff != 2'd0;
   assign out_kind = tok_ff[idx_ff].kind;
   assign out_start = 24'(tok_ff[idx_ff].start);
   assign out_length = 24'(tok_ff[idx_ff].len);
   assign out_line = tline_ff[idx_ff];
   assign out_last = idx_ff + 2'd1 == cnt_ff;

   always_comb begin
      logic [7:0]    c;
      logic [PB-1:0] p;
      logic [1:0]    n;
      logic          do_idle;
      c = in_char;
      p = pos_ff;
      n = 2'd0;
      do_idle = 1'b0;
      mode_in = mode_ff;
      look_in = look_ff;
      lex_in = lex_ff;
      line_in = line_ff;
      pre_in = pre_ff;
      ilen_in = ilen_ff;
      idx_in = '0;
      pos_in = pos_ff + PB'(1);
      // tokens always complete before any line bump of the same byte
      for (int i = 0; i < 3; i++) begin
         tok_in[i] = '0;
         tline_in[i] = line_ff;
      end
      if (in_end) begin
         pos_in = '0;
         mode_in = stok_pkg::M_IDLE;
         lex_in = '0;
         line_in = 24'd1;
         ilen_in = '0;
         look_in = '0;
         case (mode_ff)
            stok_pkg::M_SLASH: begin
               tok_in[0] = '{stok_pkg::K_SLASH, lex_ff, PB'(1)}; n = 2'd1;
            end
            stok_pkg::M_IDENT: begin
               tok_in[0] = '{kw_kind, lex_ff, p - lex_ff}; n = 2'd1;
            end
            stok_pkg::M_NUM, stok_pkg::M_FRAC: begin
               tok_in[0] = '{stok_pkg::K_NUMBER, lex_ff, p - lex_ff}; n = 2'd1;
            end
            stok_pkg::M_NUMDOT: begin
               tok_in[0] = '{stok_pkg::K_NUMBER, lex_ff, p - PB'(1) - lex_ff};
               tok_in[1] = '{stok_pkg::K_DOT, p - PB'(1), PB'(1)};
               n = 2'd2;
            end
            stok_pkg::M_OP: begin
               tok_in[0] = '{stok_pkg::op_kind(look_ff), lex_ff, PB'(1)}; n = 2'd1;
            end
            default: ;
         endcase
         if (mode_ff == stok_pkg::M_STR) begin
            tok_in[0] = '{stok_pkg::K_END, lex_ff, p - lex_ff}; n = 2'd1;
         end else begin
            tok_in[n] = '{stok_pkg::K_END, p, '0}; n = n + 2'd1;
         end
      end else begin
         case (mode_ff)
            stok_pkg::M_IDLE: do_idle = 1'b1;
            stok_pkg::M_SLASH: begin
               if (c == 8'h2f) mode_in = stok_pkg::M_LINEC;
               else if (c == 8'h2a) mode_in = stok_pkg::M_BLOCK;
               else begin
                  tok_in[0] = '{stok_pkg::K_SLASH, lex_ff, PB'(1)}; n = 2'd1;
                  do_idle = 1'b1;
               end
            end
            stok_pkg::M_LINEC: if (c == 8'h0a) begin
               mode_in = stok_pkg::M_IDLE;
               if (line_ff != 24'hffffff) line_in = line_ff + 24'd1;
            end
            stok_pkg::M_BLOCK: begin
               if (c == 8'h2a) mode_in = stok_pkg::M_BSTAR;
               else if (c == 8'h0a && line_ff != 24'hffffff) line_in = line_ff + 24'd1;
            end
            stok_pkg::M_BSTAR: begin
               if (c == 8'h2f) mode_in = stok_pkg::M_IDLE;
               else if (c != 8'h2a) begin
                  mode_in = stok_pkg::M_BLOCK;
                  if (c == 8'h0a && line_ff != 24'hffffff) line_in = line_ff + 24'd1;
               end
            end
            stok_pkg::M_IDENT: begin
               if (stok_pkg::is_alpha(c) || stok_pkg::is_dec(c)) begin
                  for (int i = 0; i < KEYWORD_MAX; i++) begin
                     if (ilen_ff == LW'(i)) pre_in[i*8 +: 8] = c;
                  end
                  if (ilen_ff <= LW'(KEYWORD_MAX)) ilen_in = ilen_ff + LW'(1);
               end else begin
                  tok_in[0] = '{kw_kind, lex_ff, p - lex_ff}; n = 2'd1;
                  do_idle = 1'b1;
               end
            end
            stok_pkg::M_NUM: begin
               if (c == 8'h2e) begin
                  mode_in = stok_pkg::M_NUMDOT; look_in = c;
               end else if (!stok_pkg::is_dec(c)) begin
                  tok_in[0] = '{stok_pkg::K_NUMBER, lex_ff, p - lex_ff}; n = 2'd1;
                  do_idle = 1'b1;
               end
            end
            stok_pkg::M_NUMDOT: begin
               if (stok_pkg::is_dec(c)) mode_in = stok_pkg::M_FRAC;
               else begin
                  tok_in[0] = '{stok_pkg::K_NUMBER, lex_ff, p - PB'(1) - lex_ff};
                  tok_in[1] = '{stok_pkg::K_DOT, p - PB'(1), PB'(1)};
                  n = 2'd2;
                  do_idle = 1'b1;
               end
            end
            stok_pkg::M_FRAC: if (!stok_pkg::is_dec(c)) begin
               tok_in[0] = '{stok_pkg::K_NUMBER, lex_ff, p - lex_ff}; n = 2'd1;
               do_idle = 1'b1;
            end
            stok_pkg::M_STR: begin
               if (c == 8'h22) begin
                  tok_in[0] = '{stok_pkg::K_STRING, lex_ff, p + PB'(1) - lex_ff};
                  n = 2'd1;
                  mode_in = stok_pkg::M_IDLE;
               end else if (c == 8'h0a && line_ff != 24'hffffff) line_in = line_ff + 24'd1;
            end
            stok_pkg::M_OP: begin
               if (c == 8'h3d) begin
                  tok_in[0] = '{stok_pkg::op_kind(look_ff) + 6'd1, lex_ff, PB'(2)};
                  n = 2'd1;
                  mode_in = stok_pkg::M_IDLE;
               end else begin
                  tok_in[0] = '{stok_pkg::op_kind(look_ff), lex_ff, PB'(1)}; n = 2'd1;
                  do_idle = 1'b1;
               end
            end
            default: do_idle = 1'b1;
         endcase
         if (do_idle) begin
            mode_in = stok_pkg::M_IDLE;
            if (c == 8'h0a) begin
               if (line_ff != 24'hffffff) line_in = line_ff + 24'd1;
            end else if (c != 8'h20 && c != 8'h0d && c != 8'h09) begin
               lex_in = p;
               if (stok_pkg::is_alpha(c)) begin
                  mode_in = stok_pkg::M_IDENT;
                  pre_in[7:0] = c;
                  ilen_in = LW'(1);
               end else if (stok_pkg::is_dec(c)) mode_in = stok_pkg::M_NUM;
               else if (c == 8'h2f) begin
                  mode_in = stok_pkg::M_SLASH; look_in = c;
               end else if (c == 8'h21 || c == 8'h3d || c == 8'h3c || c == 8'h3e) begin
                  mode_in = stok_pkg::M_OP; look_in = c;
               end else if (c == 8'h22) mode_in = stok_pkg::M_STR;
               else begin
                  tok_in[n] = '{stok_pkg::single_kind(c), p, PB'(1)};
                  n = n + 2'd1;
               end
            end
         end
      end
      cnt_in = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= stok_pkg::M_IDLE;
         look_ff <= '0;
         pos_ff <= '0;
         lex_ff <= '0;
         line_ff <= 24'd1;
         ilen_ff <= '0;
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
            look_ff <= look_in;
            pos_ff <= pos_in;
            lex_ff <= lex_in;
            line_ff <= line_in;
            ilen_ff <= ilen_in;
            cnt_ff <= cnt_in;
            idx_ff <= idx_in;
         end else if (out_valid && out_ready) begin
            if (out_last) cnt_ff <= '0;
            else idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pre_ff <= pre_in;
         for (int i = 0; i < 3; i++) begin
            tok_ff[i] <= tok_in[i];
            tline_ff[i] <= tline_in[i];
         end
      end
   end

   `ST_ASSERT(a_idx_in_range, clock, reset, !out_valid || idx_ff < cnt_ff, "index past count")
   `ST_ASSERT(a_no_accept_busy, clock, reset, !(accept && out_valid && !out_last), "overrun")
   `ST_ASSERT(a_end_resets, clock, reset, end_take |=> pos_ff == '0 && line_ff == 24'd1, "no reset")
   `ST_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !out_valid, "valid after reset")
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   typedef struct packed {
      logic        last;
      logic [23:0] line;
      logic [23:0] len;
      logic [23:0] start;
      logic [5:0]  kind;
   } token_type;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stok_stream_if #(9) req_if ();
   stok_stream_if #(79) rsp_if ();

   source_tokenizer i_dut (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source)
   );

   always #5 clock = ~clock;

   // lexer mirror
   stok_pkg::mode_type scan_st;
   logic [7:0]  pend_byte;
   logic [23:0] cur_pos;
   logic [23:0] tok_start;
   logic [23:0] line_cnt;
   logic [7:0]  word_buf [7];
   int          word_len;

   token_type expected_tokens[$];
   token_type run_tokens[$];
   int     errors = 0;
   int     cycles = 0;
   int     items_sent = 0;
   int     burst_left = 0;
   logic   hold_start = 1'b0;
   int     hold_left = 0;
   logic   stall_phase = 1'b0;

   string keywords[17] = '{"and", "class", "else", "false", "fn", "for", "if", "in", "let",
      "null", "or", "println", "return", "super", "self", "true", "while"};
   logic [5:0] keyword_kinds[17] = '{stok_pkg::K_AND, stok_pkg::K_CLASS, stok_pkg::K_ELSE,
      stok_pkg::K_FALSE, stok_pkg::K_FN, stok_pkg::K_FOR, stok_pkg::K_IF, stok_pkg::K_IN,
      stok_pkg::K_LET, stok_pkg::K_NULL, stok_pkg::K_OR, stok_pkg::K_PRINTLN,
      stok_pkg::K_RETURN, stok_pkg::K_SUPER, stok_pkg::K_SELF, stok_pkg::K_TRUE,
      stok_pkg::K_WHILE};

   function automatic logic letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [5:0] rel_kind(input logic [7:0] c);
      if (c == "!") return stok_pkg::K_BANG;
      if (c == "=") return stok_pkg::K_EQUAL;
      if (c == ">") return stok_pkg::K_GREATER;
      return stok_pkg::K_LESS;
   endfunction

   function automatic logic [5:0] word_kind();
      logic hit;
      if (word_len > stok_pkg::KEYWORD_MAX) return stok_pkg::K_IDENT;
      for (int i = 0; i < 17; i++) begin
         if (keywords[i].len() == word_len) begin
            hit = 1'b1;
            for (int j = 0; j < word_len; j++)
               if (word_buf[j] != keywords[i][j]) hit = 1'b0;
            if (hit) return keyword_kinds[i];
         end
      end
      return stok_pkg::K_IDENT;
   endfunction

   task automatic add_token(input logic [5:0] k, input logic [23:0] st,
                            input logic [23:0] ln);
      run_tokens.push_back('{kind: k, start: st, len: ln, line: line_cnt, last: 1'b0});
   endtask

   task automatic bump_line();
      if (line_cnt != 24'hFFFFFF) line_cnt++;
   endtask

   task automatic begin_lexeme(input logic [7:0] c, input logic [23:0] p);
      scan_st = stok_pkg::M_IDLE;
      if (c == " " || c == 8'h0d || c == 8'h09) return;
      if (c == 8'h0a) begin
         bump_line();
         return;
      end
      tok_start = p;
      if (letter(c)) begin
         scan_st = stok_pkg::M_IDENT;
         word_buf[0] = c;
         word_len = 1;
      end else if (digit(c)) begin
         scan_st = stok_pkg::M_NUM;
      end else begin
         case (c)
            "(": add_token(stok_pkg::K_LPAREN, p, 24'd1);
            ")": add_token(stok_pkg::K_RPAREN, p, 24'd1);
            "{": add_token(stok_pkg::K_LBRACE, p, 24'd1);
            "}": add_token(stok_pkg::K_RBRACE, p, 24'd1);
            ",": add_token(stok_pkg::K_COMMA, p, 24'd1);
            ".": add_token(stok_pkg::K_DOT, p, 24'd1);
            "-": add_token(stok_pkg::K_MINUS, p, 24'd1);
            "+": add_token(stok_pkg::K_PLUS, p, 24'd1);
            ";": add_token(stok_pkg::K_SEMI, p, 24'd1);
            "*": add_token(stok_pkg::K_STAR, p, 24'd1);
            "/": begin
               scan_st = stok_pkg::M_SLASH;
               pend_byte = c;
            end
            "!", "=", "<", ">": begin
               scan_st = stok_pkg::M_OP;
               pend_byte = c;
            end
            "\"": scan_st = stok_pkg::M_STR;
            default: add_token(stok_pkg::K_ERROR, p, 24'd1);
         endcase
      end
   endtask

   task automatic clear_lexer();
      scan_st = stok_pkg::M_IDLE;
      pend_byte = 8'h00;
      cur_pos = '0;
      tok_start = '0;
      line_cnt = 24'd1;
      word_len = 0;
   endtask

   task automatic predict_tokens(input logic [7:0] c, input logic eoi);
      logic [23:0] p;
      logic [23:0] s;
      logic        send_end;
      p = cur_pos;
      s = tok_start;
      send_end = 1'b1;
      run_tokens.delete();
      if (eoi) begin
         case (scan_st)
            stok_pkg::M_SLASH: add_token(stok_pkg::K_SLASH, s, 24'd1);
            stok_pkg::M_IDENT: add_token(word_kind(), s, p - s);
            stok_pkg::M_NUM, stok_pkg::M_FRAC: add_token(stok_pkg::K_NUMBER, s, p - s);
            stok_pkg::M_NUMDOT: begin
               add_token(stok_pkg::K_NUMBER, s, p - 24'd1 - s);
               add_token(stok_pkg::K_DOT, p - 24'd1, 24'd1);
            end
            stok_pkg::M_OP: add_token(rel_kind(pend_byte), s, 24'd1);
            stok_pkg::M_STR: begin
               add_token(stok_pkg::K_END, s, p - s);
               send_end = 1'b0;
            end
            default: ;
         endcase
         if (send_end) add_token(stok_pkg::K_END, p, 24'd0);
         clear_lexer();
      end else begin
         case (scan_st)
            stok_pkg::M_SLASH: begin
               if (c == "/") scan_st = stok_pkg::M_LINEC;
               else if (c == "*") scan_st = stok_pkg::M_BLOCK;
               else begin
                  add_token(stok_pkg::K_SLASH, s, 24'd1);
                  begin_lexeme(c, p);
               end
            end
            stok_pkg::M_LINEC: begin
               if (c == 8'h0a) begin
                  bump_line();
                  scan_st = stok_pkg::M_IDLE;
               end
            end
            stok_pkg::M_BLOCK: begin
               if (c == "*") scan_st = stok_pkg::M_BSTAR;
               else if (c == 8'h0a) bump_line();
            end
            stok_pkg::M_BSTAR: begin
               if (c == "/") scan_st = stok_pkg::M_IDLE;
               else if (c != "*") begin
                  if (c == 8'h0a) bump_line();
                  scan_st = stok_pkg::M_BLOCK;
               end
            end
            stok_pkg::M_IDENT: begin
               if (letter(c) || digit(c)) begin
                  if (word_len < stok_pkg::KEYWORD_MAX) word_buf[word_len] = c;
                  if (word_len <= stok_pkg::KEYWORD_MAX) word_len++;
               end else begin
                  add_token(word_kind(), s, p - s);
                  begin_lexeme(c, p);
               end
            end
            stok_pkg::M_NUM: begin
               if (c == ".") begin
                  scan_st = stok_pkg::M_NUMDOT;
                  pend_byte = c;
               end else if (!digit(c)) begin
                  add_token(stok_pkg::K_NUMBER, s, p - s);
                  begin_lexeme(c, p);
               end
            end
            stok_pkg::M_NUMDOT: begin
               if (digit(c)) scan_st = stok_pkg::M_FRAC;
               else begin
                  add_token(stok_pkg::K_NUMBER, s, p - 24'd1 - s);
                  add_token(stok_pkg::K_DOT, p - 24'd1, 24'd1);
                  begin_lexeme(c, p);
               end
            end
            stok_pkg::M_FRAC: begin
               if (!digit(c)) begin
                  add_token(stok_pkg::K_NUMBER, s, p - s);
                  begin_lexeme(c, p);
               end
            end
            stok_pkg::M_STR: begin
               if (c == "\"") begin
                  add_token(stok_pkg::K_STRING, s, p + 24'd1 - s);
                  scan_st = stok_pkg::M_IDLE;
               end else if (c == 8'h0a) bump_line();
            end
            stok_pkg::M_OP: begin
               if (c == "=") begin
                  add_token(rel_kind(pend_byte) + 6'd1, s, 24'd2);
                  scan_st = stok_pkg::M_IDLE;
               end else begin
                  add_token(rel_kind(pend_byte), s, 24'd1);
                  begin_lexeme(c, p);
               end
            end
            default: begin_lexeme(c, p);
         endcase
         cur_pos = p + 24'd1;
      end
      if (run_tokens.size() > 0) run_tokens[$].last = 1'b1;
      foreach (run_tokens[i]) expected_tokens.push_back(run_tokens[i]);
   endtask

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      errors++;
   endtask

   // sender: bursts of random length, random gaps between them
   task automatic send_item(input logic [7:0] c, input logic eoi);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.payload <= {eoi, c};
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      predict_tokens(c, eoi);
   endtask

   task automatic send_text(input string txt);
      for (int i = 0; i < txt.len(); i++) send_item(txt[i], 1'b0);
   endtask

   task automatic send_end();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      burst_left = 0;
      wait (expected_tokens.size() == 0);
      @(posedge clock);
   endtask

   task automatic test_punctuation_and_operators();
      send_text("(){},.-+;*/!=!==<=<>=>");
      send_end();
      send_text("x1=1.5;1.a>=\"s\n\"");
      send_end();
   endtask

   task automatic test_comments_and_errors();
      send_text("a//c\nb/*x\n**/@");
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_text("/*open");
      send_end();
      send_text("\"open\n");
      send_end();
      send_text("7.");
      send_end();
      send_text("/");
      send_end();
      send_text("<");
      send_end();
      send_end();
   endtask

   function automatic string random_word(input int n);
      string w;
      string alnum;
      alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      w = "";
      for (int i = 0; i < n; i++)
         w = {w, string'(alnum[$urandom_range(0, (i == 0) ? 52 : 62)])};
      return w;
   endfunction

   task automatic send_random_lexeme();
      string ops[12] = '{"!", "!=", "=", "==", "<", "<=", ">", ">=", "/", "*", "(", "}"};
      string t;
      case ($urandom_range(0, 11))
         0, 1: begin
            t = keywords[$urandom_range(0, 16)];
            if ($urandom_range(0, 2) == 0) t = {t, random_word(1)};
            send_text(t);
         end
         2: send_text(random_word($urandom_range(1, 10)));
         3: begin
            t = $sformatf("%0d", $urandom_range(0, 9999));
            case ($urandom_range(0, 2))
               0: t = {t, ".", $sformatf("%0d", $urandom_range(0, 99))};
               1: t = {t, "."};
               default: ;
            endcase
            send_text(t);
         end
         4: send_text({"\"", random_word($urandom_range(0, 4)), "\n \""});
         5: send_text({"//", random_word($urandom_range(0, 3)), "\n"});
         6: send_text({"/* *", random_word($urandom_range(0, 3)), "\n**/"});
         7, 8: send_text(ops[$urandom_range(0, 11)]);
         9: send_text(($urandom_range(0, 1) == 1) ? " " : "\t\r\n");
         10: send_item(8'($urandom_range(0, 255)), 1'b0);
         default: begin
            if ($urandom_range(0, 1) == 1) send_end();
            else send_text(" ");
         end
      endcase
   endtask

   task automatic test_random_source();
      int first;
      first = items_sent;
      while (items_sent - first < 20) send_random_lexeme();
      send_end();
   endtask

   task automatic test_backpressure();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      for (int i = 0; i < 4; i++) send_text("a(b);");
      send_end();
      drain();
      send_text("x <= 2.5;");
      send_end();
   endtask

   // receiver: own stall pattern plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_start && hold_left == 0) begin
         hold_left <= 300;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         if (cycles % 97 == 0) stall_phase <= ~stall_phase;
         rsp_if.ready <= stall_phase ? ($urandom_range(0, 2) != 0 && cycles % 5 != 2) : 1'b1;
      end
   end

   always @(posedge clock) begin
      token_type got;
      token_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = token_type'(rsp_if.payload);
         if (expected_tokens.size() == 0) begin
            report_mismatch("extra token kind", got.kind, -1);
         end else begin
            want = expected_tokens.pop_front();
            if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
            if (got.start != want.start) report_mismatch("start", got.start, want.start);
            if (got.len != want.len) report_mismatch("length", got.len, want.len);
            if (got.line != want.line) report_mismatch("line", got.line, want.line);
            if (got.last != want.last) report_mismatch("last", got.last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL source_tokenizer");
         $finish;
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      clear_lexer();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_punctuation_and_operators();
      test_comments_and_errors();
      drain();
      test_random_source();
      test_backpressure();
      drain();
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_tokens.size() == 0) begin
         $display("PASS source_tokenizer");
      end else begin
         $display("FAIL source_tokenizer");
      end
      $finish;
   end
endmodule
